// File: hw/rtl/y2rgb_pkg.sv
// Package for the 4:2:0 YCbCr to RGB block converter.
// Holds payload structs, register indexes, mode codes and reset constants.
// No dependencies.
package y2rgb_pkg;

  localparam int FRAC_BITS_DEF = 8;

  localparam int COEF_W = 12;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DATA_W = 12;

  localparam logic [7:0] LUMA_OFFSET = 8'd16;
  localparam logic [7:0] CHROMA_OFFSET = 8'd128;
  localparam logic [7:0] PIX_MAX = 8'd255;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_UPSAMPLE_MODE = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_COEF_LUMA     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_COEF_CR_RED   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_COEF_CR_GREEN = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_COEF_CB_GREEN = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_COEF_CB_BLUE  = 3'd5;

  // Chroma upsampling modes.
  localparam logic [1:0] MODE_ZERO      = 2'd0;
  localparam logic [1:0] MODE_REPLICATE = 2'd1;
  localparam logic [1:0] MODE_AVERAGE   = 2'd2;

  // Pixel positions inside a block.
  localparam logic [1:0] POS_TOP_LEFT     = 2'd0;
  localparam logic [1:0] POS_TOP_RIGHT    = 2'd1;
  localparam logic [1:0] POS_BOTTOM_LEFT  = 2'd2;
  localparam logic [1:0] POS_BOTTOM_RIGHT = 2'd3;

  localparam logic [1:0]        RST_UPSAMPLE_MODE = MODE_AVERAGE;
  localparam logic [COEF_W-1:0] RST_COEF_LUMA     = 12'd298;
  localparam logic [COEF_W-1:0] RST_COEF_CR_RED   = 12'd409;
  localparam logic [COEF_W-1:0] RST_COEF_CR_GREEN = 12'd208;
  localparam logic [COEF_W-1:0] RST_COEF_CB_GREEN = 12'd100;
  localparam logic [COEF_W-1:0] RST_COEF_CB_BLUE  = 12'd517;

  typedef struct packed {
    logic [7:0] y_top_left;
    logic [7:0] y_top_right;
    logic [7:0] y_bottom_left;
    logic [7:0] y_bottom_right;
    logic [7:0] cb_here;
    logic [7:0] cb_right;
    logic [7:0] cb_below;
    logic [7:0] cb_diagonal;
    logic [7:0] cr_here;
    logic [7:0] cr_right;
    logic [7:0] cr_below;
    logic [7:0] cr_diagonal;
  } y2rgb_in_t;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic [1:0] pixel_pos;
    logic       last_pixel;
  } y2rgb_out_t;

endpackage

// File: hw/rtl/ycc420_to_rgb_block_converter_core.sv
// Top level of the 4:2:0 YCbCr to RGB block converter.
// Depends on y2rgb_pkg for payload structs, register indexes and constants.
//
// Usage: one input transaction on in_* carries a 2x2 luma block plus the
// 2x2 Cb and Cr neighborhoods. The block emits four RGB pixel transactions
// on out_* in raster order (top-left, top-right, bottom-left, bottom-right),
// with last_pixel set on the fourth. Coefficients and the upsampling mode
// are written through cfg_we/cfg_index/cfg_wdata while the block is idle;
// writes to indexes past the register list are ignored.
// Throughput: one pixel per clock while the receiver does not stall. A block
// register feeds a pixel serializer, and a new block is taken in the cycle
// the previous one issues its last pixel.
// Pipeline: after its block is accepted, each pixel goes through pixel select
// and upsampling, multiply, sum, then round and clamp, each step registered.
// Reset (synchronous, rst_n low) empties the pipeline and loads the default
// BT.601 coefficients with averaging mode.
// On a stall the pipeline holds, but an empty block register may load; the output
// register keeps its pixel and nothing is dropped or repeated.
module ycc420_to_rgb_block_converter_core
  import y2rgb_pkg::*;
#(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  y2rgb_in_t             in_data,
  output logic                  out_valid,
  input  logic                  out_ready,
  output y2rgb_out_t            out_data,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  localparam int ACC_W = 25;
  localparam int LP_W = 22;   // luma product width
  localparam int CP_W = 21;   // chroma product width
  localparam logic signed [ACC_W-1:0] ROUND_C = ACC_W'(1) <<< (FRAC_BITS - 1);

  // Configuration registers.
  logic [1:0]        mode_r;
  logic [COEF_W-1:0] coef_luma_r, coef_cr_red_r, coef_cr_green_r;
  logic [COEF_W-1:0] coef_cb_green_r, coef_cb_blue_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r          <= RST_UPSAMPLE_MODE;
      coef_luma_r     <= RST_COEF_LUMA;
      coef_cr_red_r   <= RST_COEF_CR_RED;
      coef_cr_green_r <= RST_COEF_CR_GREEN;
      coef_cb_green_r <= RST_COEF_CB_GREEN;
      coef_cb_blue_r  <= RST_COEF_CB_BLUE;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_UPSAMPLE_MODE: mode_r          <= cfg_wdata[1:0];
        REG_COEF_LUMA:     coef_luma_r     <= cfg_wdata[COEF_W-1:0];
        REG_COEF_CR_RED:   coef_cr_red_r   <= cfg_wdata[COEF_W-1:0];
        REG_COEF_CR_GREEN: coef_cr_green_r <= cfg_wdata[COEF_W-1:0];
        REG_COEF_CB_GREEN: coef_cb_green_r <= cfg_wdata[COEF_W-1:0];
        REG_COEF_CB_BLUE:  coef_cb_blue_r  <= cfg_wdata[COEF_W-1:0];
        default: ;
      endcase
    end
  end

  // The whole pipeline advances together unless the output is held.
  logic adv;
  logic out_valid_r;
  assign adv = !out_valid_r || out_ready;

  // Block register and pixel serializer.
  y2rgb_in_t blk_r;
  logic      blk_valid_r;
  logic [1:0] pos_r;
  logic      in_acc;

  assign in_ready = !blk_valid_r || (adv && pos_r == POS_BOTTOM_RIGHT);
  assign in_acc   = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      blk_valid_r <= 1'b0;
      pos_r       <= POS_TOP_LEFT;
    end else if (in_acc) begin
      blk_valid_r <= 1'b1;
      pos_r       <= POS_TOP_LEFT;
    end else if (blk_valid_r && adv) begin
      pos_r <= pos_r + 2'd1;
      if (pos_r == POS_BOTTOM_RIGHT) begin
        blk_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      blk_r <= in_data;
    end
  end

  // Stage 1: pick the pixel's luma and rebuild its chroma.
  function automatic logic [7:0] upsample(input logic [1:0] mode, input logic [1:0] pos,
                                          input logic [7:0] c00, input logic [7:0] c01,
                                          input logic [7:0] c10, input logic [7:0] c11);
    logic [8:0] sum_h;
    logic [8:0] sum_v;
    logic [9:0] sum_q;
    logic [7:0] res;
    sum_h = {1'b0, c00} + {1'b0, c01} + 9'd1;
    sum_v = {1'b0, c00} + {1'b0, c10} + 9'd1;
    sum_q = {2'b00, c00} + {2'b00, c01} + {2'b00, c10} + {2'b00, c11} + 10'd2;
    res = c00;
    if (pos != POS_TOP_LEFT) begin
      case (mode)
        MODE_ZERO: res = 8'd0;
        MODE_AVERAGE: begin
          case (pos)
            POS_TOP_RIGHT:   res = sum_h[8:1];
            POS_BOTTOM_LEFT: res = sum_v[8:1];
            default:         res = sum_q[9:2];
          endcase
        end
        default: res = c00;   // replicate, and the unused code acts alike
      endcase
    end
    return res;
  endfunction

  logic       s1_valid_r;
  logic [1:0] s1_pos_r;
  logic [7:0] s1_y_r, s1_cb_r, s1_cr_r;
  logic [7:0] y_sel;

  always_comb begin
    case (pos_r)
      POS_TOP_LEFT:    y_sel = blk_r.y_top_left;
      POS_TOP_RIGHT:   y_sel = blk_r.y_top_right;
      POS_BOTTOM_LEFT: y_sel = blk_r.y_bottom_left;
      default:         y_sel = blk_r.y_bottom_right;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (adv) begin
      s1_valid_r <= blk_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_pos_r <= pos_r;
      s1_y_r   <= y_sel;
      s1_cb_r  <= upsample(mode_r, pos_r, blk_r.cb_here, blk_r.cb_right,
                           blk_r.cb_below, blk_r.cb_diagonal);
      s1_cr_r  <= upsample(mode_r, pos_r, blk_r.cr_here, blk_r.cr_right,
                           blk_r.cr_below, blk_r.cr_diagonal);
    end
  end

  // Stage 2: remove offsets and multiply by the coefficients.
  logic signed [9:0] y_d;
  logic signed [8:0] cb_d, cr_d;
  logic signed [COEF_W:0] k_luma, k_cr_red, k_cr_green, k_cb_green, k_cb_blue;

  assign y_d  = signed'({2'b00, s1_y_r}) - signed'({2'b00, LUMA_OFFSET});
  assign cb_d = signed'({1'b0, s1_cb_r}) - signed'({1'b0, CHROMA_OFFSET});
  assign cr_d = signed'({1'b0, s1_cr_r}) - signed'({1'b0, CHROMA_OFFSET});
  assign k_luma     = signed'({1'b0, coef_luma_r});
  assign k_cr_red   = signed'({1'b0, coef_cr_red_r});
  assign k_cr_green = signed'({1'b0, coef_cr_green_r});
  assign k_cb_green = signed'({1'b0, coef_cb_green_r});
  assign k_cb_blue  = signed'({1'b0, coef_cb_blue_r});

  logic                   s2_valid_r;
  logic [1:0]             s2_pos_r;
  logic signed [LP_W-1:0] s2_ly_r;
  logic signed [CP_W-1:0] s2_rr_r, s2_gr_r, s2_gb_r, s2_bb_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_valid_r <= 1'b0;
    end else if (adv) begin
      s2_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s2_pos_r <= s1_pos_r;
      s2_ly_r  <= LP_W'(k_luma) * LP_W'(y_d);
      s2_rr_r  <= CP_W'(k_cr_red) * CP_W'(cr_d);
      s2_gr_r  <= CP_W'(k_cr_green) * CP_W'(cr_d);
      s2_gb_r  <= CP_W'(k_cb_green) * CP_W'(cb_d);
      s2_bb_r  <= CP_W'(k_cb_blue) * CP_W'(cb_d);
    end
  end

  // Stage 3: sum the terms with the rounding constant.
  logic                    s3_valid_r;
  logic [1:0]              s3_pos_r;
  logic signed [ACC_W-1:0] s3_red_r, s3_green_r, s3_blue_r;
  logic signed [ACC_W-1:0] ly_ext;

  assign ly_ext = ACC_W'(s2_ly_r) + ROUND_C;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s3_valid_r <= 1'b0;
    end else if (adv) begin
      s3_valid_r <= s2_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s3_pos_r   <= s2_pos_r;
      s3_red_r   <= ly_ext + ACC_W'(s2_rr_r);
      s3_green_r <= ly_ext - ACC_W'(s2_gr_r) - ACC_W'(s2_gb_r);
      s3_blue_r  <= ly_ext + ACC_W'(s2_bb_r);
    end
  end

  // Stage 4: floor shift and clamp into the output register.
  function automatic logic [7:0] clamp_px(input logic signed [ACC_W-1:0] acc);
    logic signed [ACC_W-1:0] sh;
    logic [7:0] res;
    sh = acc >>> FRAC_BITS;
    if (sh[ACC_W-1]) begin
      res = 8'd0;
    end else if (sh > signed'(ACC_W'(PIX_MAX))) begin
      res = PIX_MAX;
    end else begin
      res = sh[7:0];
    end
    return res;
  endfunction

  y2rgb_out_t out_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= s3_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_r.red        <= clamp_px(s3_red_r);
      out_r.green      <= clamp_px(s3_green_r);
      out_r.blue       <= clamp_px(s3_blue_r);
      out_r.pixel_pos  <= s3_pos_r;
      out_r.last_pixel <= (s3_pos_r == POS_BOTTOM_RIGHT);
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  // A newly accepted block always starts at the top-left pixel.
  a_new_block_pos: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> blk_valid_r && pos_r == POS_TOP_LEFT)
    else $error("block register did not restart at top-left");

  // The serializer steps one pixel per advancing cycle within a block.
  a_serial_step: assert property (@(posedge clk) disable iff (!rst_n)
    blk_valid_r && adv && pos_r != POS_BOTTOM_RIGHT && !in_acc |=>
      blk_valid_r && pos_r == $past(pos_r) + 2'd1)
    else $error("pixel serializer skipped or repeated a pixel");

  // A stall freezes the pixel stream inside the pipeline; only an empty block
  // register may still take a new transaction.
  a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
    !adv |=> $stable(s1_valid_r) && $stable(s2_valid_r) && $stable(s3_valid_r)
             && $stable(pos_r) && ($stable(blk_valid_r) || $past(in_acc)))
    else $error("pipeline moved during an output stall");

  // The last-pixel flag marks exactly the bottom-right pixel.
  a_last_flag: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_r.last_pixel == (out_r.pixel_pos == POS_BOTTOM_RIGHT)))
    else $error("last_pixel does not match pixel position");

endmodule
